[rtl/core/lrs_pkg.sv]
// shared types and constants for the lsd radix sorter
package lrs_pkg;

   // record field widths
   localparam int unsigned KEY_BITS = 30;
   localparam int unsigned PAY_BITS = 32;
   localparam int unsigned REC_BITS = KEY_BITS + PAY_BITS;

   // input item
   typedef struct packed {
      logic [KEY_BITS-1:0] sort_key;
      logic [PAY_BITS-1:0] payload;
      logic                last_in;
   } req_type;

   // result item
   typedef struct packed {
      logic [KEY_BITS-1:0] sorted_key;
      logic [PAY_BITS-1:0] sorted_payload;
      logic                last_out;
      logic                overflowed;
   } rsp_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_CNT_RD,
      ST_CNT_DIG,
      ST_CNT_WR,
      ST_PFX_RD,
      ST_PFX_WR,
      ST_SCT_RD,
      ST_SCT_DIG,
      ST_SCT_WR,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

endpackage

[rtl/core/lrs_ram.sv]
// generic single-write, single-read ram with registered read data
module lrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/core/lsd_radix_sort_30bit_keys.sv]
// lsd radix sorter: loads records, sorts by key over digit passes, emits in order
//
// Records load at one per cycle while busy is low; the record with last_in set
// raises busy and starts the sort. Each of PASSES passes clears the
// 2^DIGIT_BITS bucket counters (one per cycle), counts digits (read, digit and
// write states per record), forms the exclusive prefix (read and write states
// per bucket) and scatters into the other buffer (read, digit and write states
// per record), all through the one bucket counter ram, which has a single write
// port and a single read port. Results then come out through a read state and an
// output state per record, each shown for one cycle under rsp_valid; the
// receiver cannot stall them, so it must take every strobe. Records beyond
// CAPACITY are dropped and reported through overflowed on every result of that
// set.
module lsd_radix_sort_30bit_keys #(
   parameter int CAPACITY   = 64,
   parameter int DIGIT_BITS = 10,
   parameter int PASSES     = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lrs_pkg::req_type req_item,
   output logic             rsp_valid,
   output lrs_pkg::rsp_type rsp_item
);

   localparam int NUM_BUCKETS = 1 << DIGIT_BITS;
   localparam int REC_AW      = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int PASS_W      = $clog2(PASSES + 1);
   localparam int SHIFT_W     = $clog2(PASSES * DIGIT_BITS + 1);
   localparam int RB          = lrs_pkg::REC_BITS;
   localparam int PB          = lrs_pkg::PAY_BITS;

   // control registers
   lrs_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  ovf_ff, ovf_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [DIGIT_BITS-1:0] bkt_ff, bkt_in;
   logic [PASS_W-1:0]     pass_ff, pass_in;
   logic [SHIFT_W-1:0]    shift_ff, shift_in;

   // datapath registers
   logic [CNT_W-1:0]      sum_ff, sum_in;
   logic [DIGIT_BITS-1:0] dig_ff, dig_in;
   logic [RB-1:0]         rec_ff, rec_in;

   // ram ports
   logic                  a_wr_en, b_wr_en;
   logic [REC_AW-1:0]     a_wr_addr, b_wr_addr, buf_rd_addr;
   logic [RB-1:0]         a_wr_data, b_wr_data, a_rd_data, b_rd_data;
   logic                  c_wr_en;
   logic [DIGIT_BITS-1:0] c_wr_addr, c_rd_addr;
   logic [CNT_W-1:0]      c_wr_data, c_rd_data;

   // misc combinational
   logic                  accept, room, idx_last, bkt_last, pass_last, dst_is_b;
   logic [CNT_W-1:0]      idx_nxt;
   logic [RB-1:0]         src_rec, dst_rec, load_rec;
   logic [lrs_pkg::KEY_BITS-1:0] src_key, key_sh;
   logic [DIGIT_BITS-1:0] src_dig;

   lrs_ram #(.WIDTH(RB), .DEPTH(CAPACITY)) u_buf_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (a_wr_data),
      .rd_addr (buf_rd_addr),
      .rd_data (a_rd_data)
   );

   lrs_ram #(.WIDTH(RB), .DEPTH(CAPACITY)) u_buf_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data),
      .rd_addr (buf_rd_addr),
      .rd_data (b_rd_data)
   );

   lrs_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BUCKETS)) u_counts (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_data)
   );

   // status decode
   assign busy      = (state_ff != lrs_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign room      = (cnt_ff < CNT_W'(CAPACITY));
   assign idx_nxt   = idx_ff + CNT_W'(1);
   assign idx_last  = (idx_nxt == cnt_ff);
   assign bkt_last  = &bkt_ff;
   assign pass_last = (pass_ff == PASS_W'(PASSES - 1));
   assign dst_is_b  = ~pass_ff[0];
   assign load_rec  = {req_item.sort_key, req_item.payload};

   // ping-pong source and destination read data
   assign src_rec = dst_is_b ? a_rd_data : b_rd_data;
   assign dst_rec = dst_is_b ? b_rd_data : a_rd_data;

   // digit extraction, zero once the digit starts above the key
   assign src_key = src_rec[RB-1:PB];
   assign key_sh  = src_key >> shift_ff;
   assign src_dig = (32'(shift_ff) >= lrs_pkg::KEY_BITS) ? '0 : key_sh[DIGIT_BITS-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lrs_pkg::ST_IDLE: begin
            if (accept && req_item.last_in) begin
               state_in = lrs_pkg::ST_CLEAR;
            end
         end
         lrs_pkg::ST_CLEAR: begin
            if (bkt_last) begin
               state_in = lrs_pkg::ST_CNT_RD;
            end
         end
         lrs_pkg::ST_CNT_RD:  state_in = lrs_pkg::ST_CNT_DIG;
         lrs_pkg::ST_CNT_DIG: state_in = lrs_pkg::ST_CNT_WR;
         lrs_pkg::ST_CNT_WR: begin
            state_in = idx_last ? lrs_pkg::ST_PFX_RD : lrs_pkg::ST_CNT_RD;
         end
         lrs_pkg::ST_PFX_RD:  state_in = lrs_pkg::ST_PFX_WR;
         lrs_pkg::ST_PFX_WR: begin
            state_in = bkt_last ? lrs_pkg::ST_SCT_RD : lrs_pkg::ST_PFX_RD;
         end
         lrs_pkg::ST_SCT_RD:  state_in = lrs_pkg::ST_SCT_DIG;
         lrs_pkg::ST_SCT_DIG: state_in = lrs_pkg::ST_SCT_WR;
         lrs_pkg::ST_SCT_WR: begin
            if (!idx_last) begin
               state_in = lrs_pkg::ST_SCT_RD;
            end else if (pass_last) begin
               state_in = lrs_pkg::ST_EMIT_RD;
            end else begin
               state_in = lrs_pkg::ST_CLEAR;
            end
         end
         lrs_pkg::ST_EMIT_RD: state_in = lrs_pkg::ST_EMIT_OUT;
         lrs_pkg::ST_EMIT_OUT: begin
            state_in = idx_last ? lrs_pkg::ST_IDLE : lrs_pkg::ST_EMIT_RD;
         end
         default: state_in = lrs_pkg::ST_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      idx_in      = idx_ff;
      bkt_in      = bkt_ff;
      pass_in     = pass_ff;
      shift_in    = shift_ff;
      sum_in      = sum_ff;
      dig_in      = dig_ff;
      rec_in      = rec_ff;
      a_wr_en     = 1'b0;
      a_wr_addr   = cnt_ff[REC_AW-1:0];
      a_wr_data   = load_rec;
      b_wr_en     = 1'b0;
      b_wr_addr   = c_rd_data[REC_AW-1:0];
      b_wr_data   = rec_ff;
      buf_rd_addr = idx_ff[REC_AW-1:0];
      c_wr_en     = 1'b0;
      c_wr_addr   = dig_ff;
      c_wr_data   = c_rd_data + CNT_W'(1);
      c_rd_addr   = src_dig;
      rsp_valid   = 1'b0;
      rsp_item.sorted_key     = dst_rec[RB-1:PB];
      rsp_item.sorted_payload = dst_rec[PB-1:0];
      rsp_item.last_out       = idx_last;
      rsp_item.overflowed     = ovf_ff;
      unique case (state_ff)
         lrs_pkg::ST_IDLE: begin
            // store the item in arrival order, or drop it when full
            if (accept) begin
               if (room) begin
                  a_wr_en = 1'b1;
                  cnt_in  = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               bkt_in   = '0;
               pass_in  = '0;
               shift_in = '0;
            end
         end
         lrs_pkg::ST_CLEAR: begin
            c_wr_en   = 1'b1;
            c_wr_addr = bkt_ff;
            c_wr_data = '0;
            bkt_in    = bkt_ff + DIGIT_BITS'(1);
            idx_in    = '0;
         end
         lrs_pkg::ST_CNT_RD: begin
         end
         lrs_pkg::ST_CNT_DIG: begin
            dig_in = src_dig;
         end
         lrs_pkg::ST_CNT_WR: begin
            // bump the bucket of this record's digit
            c_wr_en = 1'b1;
            idx_in  = idx_nxt;
            bkt_in  = '0;
            sum_in  = '0;
         end
         lrs_pkg::ST_PFX_RD: begin
            c_rd_addr = bkt_ff;
         end
         lrs_pkg::ST_PFX_WR: begin
            // exclusive prefix: bucket takes the running sum
            c_wr_en   = 1'b1;
            c_wr_addr = bkt_ff;
            c_wr_data = sum_ff;
            sum_in    = sum_ff + c_rd_data;
            bkt_in    = bkt_ff + DIGIT_BITS'(1);
            idx_in    = '0;
         end
         lrs_pkg::ST_SCT_RD: begin
         end
         lrs_pkg::ST_SCT_DIG: begin
            dig_in = src_dig;
            rec_in = src_rec;
         end
         lrs_pkg::ST_SCT_WR: begin
            // place the record at its bucket slot and advance the slot
            c_wr_en   = 1'b1;
            a_wr_en   = !dst_is_b;
            a_wr_addr = c_rd_data[REC_AW-1:0];
            a_wr_data = rec_ff;
            b_wr_en   = dst_is_b;
            idx_in    = idx_nxt;
            if (idx_last) begin
               idx_in = '0;
               bkt_in = '0;
               if (!pass_last) begin
                  pass_in  = pass_ff + PASS_W'(1);
                  shift_in = shift_ff + SHIFT_W'(DIGIT_BITS);
               end
            end
         end
         lrs_pkg::ST_EMIT_RD: begin
         end
         lrs_pkg::ST_EMIT_OUT: begin
            rsp_valid = 1'b1;
            idx_in    = idx_nxt;
            if (idx_last) begin
               cnt_in = '0;
               ovf_in = 1'b0;
               idx_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrs_pkg::ST_IDLE;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         idx_ff   <= '0;
         bkt_ff   <= '0;
         pass_ff  <= '0;
         shift_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         idx_ff   <= idx_in;
         bkt_ff   <= bkt_in;
         pass_ff  <= pass_in;
         shift_ff <= shift_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      dig_ff <= dig_in;
      rec_ff <= rec_in;
   end

   // checks
   a_last_starts_sort: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.last_in |=> busy)
      else $error("last item did not start the sort");

   a_strobe_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe on two cycles in a row");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("record count above capacity");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last_out |=> !busy && cnt_ff == '0 && !ovf_ff)
      else $error("set not closed after final result");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == lrs_pkg::ST_SCT_WR |-> c_rd_data < cnt_ff)
      else $error("scatter slot beyond stored records");

endmodule

[tb/tb_lsd_radix_sort_30bit_keys.sv]
// testbench for the lsd radix sorter: record sets in, sorted records checked out
`timescale 1ns / 100ps

module tb_lsd_radix_sort_30bit_keys;

   // record widths from the package
   localparam int unsigned KEY_BITS    = lrs_pkg::KEY_BITS;
   localparam int unsigned PAY_BITS    = lrs_pkg::PAY_BITS;
   localparam int unsigned REC_BITS    = lrs_pkg::REC_BITS;

   // sorter geometry as built into the block
   localparam int unsigned SET_DEPTH   = 64;
   localparam int unsigned DIGIT_W     = 10;
   localparam int unsigned DIGIT_MASK  = 32'h3FF;
   localparam int unsigned BUCKETS     = 1024;
   localparam int unsigned NUM_PASSES  = 3;
   localparam int unsigned ITEM_TARGET = 370;
   localparam int unsigned SETTLE_CYC  = 100;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   lrs_pkg::req_type req_item = '0;
   logic             rsp_valid;
   lrs_pkg::rsp_type rsp_item;

   // items waiting to be offered, and sorted records still to come out
   lrs_pkg::req_type load_queue [$];
   lrs_pkg::rsp_type sorted_due [$];

   // shadow copy of the records held for the current set
   logic [REC_BITS-1:0] held_records [$];
   logic                set_dropped = 1'b0;

   int unsigned items_queued   = 0;
   int unsigned items_taken    = 0;
   int unsigned sets_sorted    = 0;
   int unsigned overflow_sets  = 0;
   int unsigned results_seen   = 0;
   int unsigned failures       = 0;
   int unsigned hold_off       = 0;
   bit          idle_mode      = 1'b1;
   longint unsigned cycle_count = 0;
   longint unsigned cycle_limit = 64'd5000000;
   lrs_pkg::rsp_type due;

   lsd_radix_sort_30bit_keys DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // digit of a stored record for a pass starting at bit shift
   function automatic int unsigned key_digit(input logic [REC_BITS-1:0] rec,
                                             input int unsigned shift);
      logic [KEY_BITS-1:0] k;
      k = rec[REC_BITS-1:PAY_BITS];
      if (shift >= KEY_BITS) return 0;
      return (int'(k) >> shift) & DIGIT_MASK;
   endfunction

   // stable counting passes over the held set, then queue the sorted records
   task automatic sort_held_set();
      logic [REC_BITS-1:0] src [SET_DEPTH];
      logic [REC_BITS-1:0] dst [SET_DEPTH];
      int unsigned tally [BUCKETS];
      int unsigned n, run_sum, cnt, pos, dig, shift;
      lrs_pkg::rsp_type r;
      n = held_records.size();
      for (int unsigned i = 0; i < n; i++) src[i] = held_records[i];
      for (int unsigned p = 0; p < NUM_PASSES; p++) begin
         shift = p * DIGIT_W;
         for (int unsigned b = 0; b < BUCKETS; b++) tally[b] = 0;
         for (int unsigned i = 0; i < n; i++) tally[key_digit(src[i], shift)]++;
         run_sum = 0;
         for (int unsigned b = 0; b < BUCKETS; b++) begin
            cnt = tally[b];
            tally[b] = run_sum;
            run_sum += cnt;
         end
         for (int unsigned i = 0; i < n; i++) begin
            dig = key_digit(src[i], shift);
            pos = tally[dig];
            tally[dig]++;
            if (pos < SET_DEPTH) dst[pos] = src[i];
         end
         for (int unsigned i = 0; i < n; i++) src[i] = dst[i];
      end
      for (int unsigned i = 0; i < n; i++) begin
         r.sorted_key     = src[i][REC_BITS-1:PAY_BITS];
         r.sorted_payload = src[i][PAY_BITS-1:0];
         r.last_out       = (i + 1 == n);
         r.overflowed     = set_dropped;
         sorted_due.push_back(r);
      end
      if (set_dropped) overflow_sets++;
      sets_sorted++;
      held_records.delete();
      set_dropped = 1'b0;
   endtask

   // store one accepted record; a marked record closes the set
   task automatic take_record(input lrs_pkg::req_type it);
      if (held_records.size() < SET_DEPTH)
         held_records.push_back({it.sort_key, it.payload});
      else
         set_dropped = 1'b1;
      if (it.last_in) sort_held_set();
   endtask

   task automatic queue_record(input logic [KEY_BITS-1:0] k, input logic [PAY_BITS-1:0] pay,
                               input logic last);
      lrs_pkg::req_type it;
      it.sort_key = k;
      it.payload  = pay;
      it.last_in  = last;
      load_queue.push_back(it);
      items_queued++;
   endtask

   // digits clustered at the bucket extremes so that buckets collide
   function automatic logic [DIGIT_W-1:0] pick_clustered_digit();
      case ($urandom_range(0, 3))
         0: return 10'd0;
         1: return 10'd1;
         2: return 10'd2;
         default: return 10'h3FF;
      endcase
   endfunction

   function automatic logic [KEY_BITS-1:0] draw_key(input logic [KEY_BITS-1:0] prev);
      int unsigned mode;
      logic [KEY_BITS-1:0] k;
      mode = $urandom_range(0, 9);
      if (mode <= 3)
         k = KEY_BITS'($urandom);
      else if (mode <= 6)
         k = {pick_clustered_digit(), pick_clustered_digit(), pick_clustered_digit()};
      else if (mode == 7)
         k = prev;
      else
         k = KEY_BITS'($urandom_range(0, 1023)) << (DIGIT_W * $urandom_range(0, 2));
      return k;
   endfunction

   task automatic queue_random_set(input int unsigned count);
      logic [KEY_BITS-1:0] k;
      k = KEY_BITS'($urandom);
      for (int unsigned i = 0; i < count; i++) begin
         k = draw_key(k);
         queue_record(k, $urandom, i + 1 == count);
      end
   endtask

   task automatic report_failure(input string what);
      failures++;
      if (failures <= 10) $display("%s", what);
   endtask

   // stimulus, then wait for the last results
   initial begin
      int unsigned set_count;
      int unsigned sz;
      // single-record sets at the key and payload extremes
      queue_record(30'h3FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      queue_record(30'h0000_0000, 32'h0000_0000, 1'b1);
      // every digit position decides somewhere, equal keys spread apart
      queue_record(30'h0000_0005, 32'h0000_0001, 1'b0);
      queue_record(30'h0000_0003, 32'hFFFF_FFFF, 1'b0);
      queue_record(30'h000F_FC00, 32'h8000_0000, 1'b0);
      queue_record(30'h3FF0_0000, 32'h1234_5678, 1'b0);
      queue_record(30'h0000_0400, 32'h0000_0002, 1'b0);
      queue_record(30'h0001_2345, 32'h0000_0003, 1'b0);
      queue_record(30'h0001_2345, 32'h0000_0001, 1'b0);
      queue_record(30'h3FFF_FFFF, 32'h0000_0000, 1'b0);
      queue_record(30'h0000_0000, 32'h5555_5555, 1'b0);
      queue_record(30'h2000_0000, 32'hAAAA_AAAA, 1'b0);
      queue_record(30'h0001_2345, 32'h0000_0002, 1'b0);
      queue_record(30'h0000_0001, 32'h7FFF_FFFF, 1'b1);
      // all keys equal: arrival order must survive
      queue_record(30'h1555_5555, 32'h0000_0030, 1'b0);
      queue_record(30'h1555_5555, 32'h0000_0010, 1'b0);
      queue_record(30'h1555_5555, 32'h0000_0020, 1'b1);
      set_count = 5;
      // exactly full, then overflowing with the marked record dropped
      queue_random_set(SET_DEPTH);
      queue_random_set(SET_DEPTH + 3);
      set_count += 2;
      while (items_queued < ITEM_TARGET) begin
         sz = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 20);
         queue_random_set(sz);
         set_count++;
      end
      // the watchdog limit grows with the number of sets and of records queued
      cycle_limit = 64'(set_count) * 40000 + 64'(items_queued) * 64 + 50000;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (items_taken < items_queued) @(posedge clock);
      while (sorted_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);

      $display("sorted %0d sets from %0d records (%0d with dropped records)",
               sets_sorted, items_taken, overflow_sets);
      $display("checked %0d results, %0d failures", results_seen, failures);
      if (failures == 0) begin
         $display("tb_lsd_radix_sort_30bit_keys: clean");
      end else begin
         $display("tb_lsd_radix_sort_30bit_keys: errors");
      end
      $finish;
   end

   // driver: offers queued items, with random gaps while idle_mode holds and over 40 items wait
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            take_record(req_item);
            items_taken++;
            if (req_item.last_in) idle_mode = ($urandom_range(0, 2) != 0);
         end
         if (!start || !busy) begin
            if (hold_off > 0) begin
               hold_off--;
               start <= 1'b0;
            end else if (load_queue.size() > 40 && idle_mode && $urandom_range(0, 4) == 0) begin
               hold_off = $urandom_range(1, 15) - 1;
               start <= 1'b0;
            end else if (load_queue.size() > 0) begin
               req_item <= load_queue.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobe must match the oldest sorted record due
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (sorted_due.size() == 0) begin
            report_failure($sformatf("unexpected result key %h payload %h",
                                     rsp_item.sorted_key, rsp_item.sorted_payload));
         end else begin
            due = sorted_due.pop_front();
            if (rsp_item.sorted_key !== due.sorted_key ||
                rsp_item.sorted_payload !== due.sorted_payload ||
                rsp_item.last_out !== due.last_out ||
                rsp_item.overflowed !== due.overflowed) begin
               report_failure($sformatf(
                  "mismatch: key %h/%h payload %h/%h last %b/%b ovf %b/%b (exp/got)",
                  due.sorted_key, rsp_item.sorted_key,
                  due.sorted_payload, rsp_item.sorted_payload,
                  due.last_out, rsp_item.last_out,
                  due.overflowed, rsp_item.overflowed));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("timeout after %0d cycles, %0d results still due",
                  cycle_count, sorted_due.size());
         $display("tb_lsd_radix_sort_30bit_keys: errors");
         $finish;
      end
   end

endmodule
